[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and helpers for the touch scan sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Converter FIFO depth bounds the samples per phase
  localparam int FIFO_DEPTH   = 16;
  // Meaningful bits of a converter word
  localparam int SAMPLE_WIDTH = 16;

  localparam int WORD_W  = 16;
  localparam int CMD_W   = 24;
  localparam int CNT_W   = 5;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int PD_BIT  = 16;

  localparam logic [CNT_W-1:0]  CNT_MIN = 5'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(FIFO_DEPTH);
  localparam logic [WORD_W-1:0] SAMPLE_MASK = WORD_W'((1 << SAMPLE_WIDTH) - 1);

  // Register reset values
  localparam logic [CNT_W-1:0] X_CNT_RST = 5'd14;
  localparam logic [CNT_W-1:0] Y_CNT_RST = 5'd12;
  localparam logic [CMD_W-1:0] X_CMD_RST = 24'hd10000;
  localparam logic [CMD_W-1:0] Y_CMD_RST = 24'h910000;
  localparam logic [CMD_W-1:0] Z_CMD_RST = 24'hc00000;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_X_CNT = 3'd0,
    REG_Y_CNT = 3'd1,
    REG_X_CMD = 3'd2,
    REG_Y_CMD = 3'd3,
    REG_Z_CMD = 3'd4
  } reg_idx_t;

  // Request types
  localparam logic REQ_PEN = 1'b0;
  localparam logic REQ_ADC = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  // What one accepted beat asks the emitter to send
  typedef enum logic [1:0] {
    JOB_PRESS   = 2'd0,   // key press, then a burst
    JOB_REPORT  = 2'd1,   // position report, then a burst
    JOB_RELEASE = 2'd2    // key release, then a zero report
  } job_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] x_cnt;
    logic [CNT_W-1:0] y_cnt;
    logic [CMD_W-1:0] x_cmd;
    logic [CMD_W-1:0] y_cmd;
    logic [CMD_W-1:0] z_cmd;
  } cfg_t;

  typedef struct packed {
    job_mode_t         mode;
    logic [CNT_W-1:0]  burst_n;
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
  } job_t;

  // Samples per phase, held within the FIFO's reach
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c < CNT_MIN) r = CNT_MIN;
    else if (c > CNT_MAX) r = CNT_MAX;
    return r;
  endfunction

endpackage

[rtl/tss_if.sv]
// ----------------------------------------------------------------------------
// tss_if
// Valid/ready channels for pen/converter beats and for result beats.
// ----------------------------------------------------------------------------
interface tss_req_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic              pen_down;
  logic [WORD_W-1:0] adc_word;

  modport source (output valid, output req_type, output pen_down, output adc_word,
                  input ready);
  modport sink   (input valid, input req_type, input pen_down, input adc_word,
                  output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [CMD_W-1:0]  command_word;
  logic              touch;
  logic [WORD_W-1:0] pos_x;
  logic [WORD_W-1:0] pos_y;
  logic              last;

  modport source (output valid, output out_kind, output command_word, output touch,
                  output pos_x, output pos_y, output last, input ready);
  modport sink   (input valid, input out_kind, input command_word, input touch,
                  input pos_x, input pos_y, input last, output ready);
endinterface

[rtl/tss_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tss_cfg_regs
// APB register file: sample counts and converter command words.
// ----------------------------------------------------------------------------
module tss_cfg_regs import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_cnt <= X_CNT_RST;
      cfg.y_cnt <= Y_CNT_RST;
      cfg.x_cmd <= X_CMD_RST;
      cfg.y_cmd <= Y_CMD_RST;
      cfg.z_cmd <= Z_CMD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_X_CNT: cfg.x_cnt <= pwdata[CNT_W-1:0];
        REG_Y_CNT: cfg.y_cnt <= pwdata[CNT_W-1:0];
        REG_X_CMD: cfg.x_cmd <= pwdata[CMD_W-1:0];
        REG_Y_CMD: cfg.y_cmd <= pwdata[CMD_W-1:0];
        REG_Z_CMD: cfg.z_cmd <= pwdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_X_CNT: prdata = DATA_W'(cfg.x_cnt);
      REG_Y_CNT: prdata = DATA_W'(cfg.y_cnt);
      REG_X_CMD: prdata = DATA_W'(cfg.x_cmd);
      REG_Y_CMD: prdata = DATA_W'(cfg.y_cmd);
      REG_Z_CMD: prdata = DATA_W'(cfg.z_cmd);
      default:   prdata = '0;
    endcase
  end

endmodule

[rtl/tss_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// tss_scan_ctrl
// Phase state, sample history and averaging; turns a pen-down or phase-ending beat into a job.
// ----------------------------------------------------------------------------
module tss_scan_ctrl import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic              req_type,
  input  logic              pen_down,
  input  logic [WORD_W-1:0] adc_word,
  output logic              job_valid,
  output job_t              job
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2,
    PH_Z    = 2'd3
  } phase_t;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  word_count, word_count_next;
  logic [WORD_W-1:0] newest_word, second_word, third_word;
  logic [WORD_W-1:0] newest_word_next, second_word_next, third_word_next;
  logic [WORD_W-1:0] held_x, held_y, held_x_next, held_y_next;

  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  count_inc;
  logic [17:0]       sum;
  logic [WORD_W-1:0] avg;
  phase_t            after;

  function automatic logic [CNT_W-1:0] phase_count(input phase_t ph, input cfg_t c);
    logic [CNT_W-1:0] r;
    case (ph)
      PH_X:    r = clamp_count(c.x_cnt);
      PH_Y:    r = clamp_count(c.y_cnt);
      default: r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] phase_cmd(input phase_t ph, input cfg_t c);
    logic [CMD_W-1:0] r;
    case (ph)
      PH_X:    r = c.x_cmd;
      PH_Y:    r = c.y_cmd;
      default: r = c.z_cmd;
    endcase
    return r;
  endfunction

  assign word      = adc_word & SAMPLE_MASK;
  assign count_inc = CNT_W'(word_count + 5'd1);
  // (2*newest + second + third) / 4 over the shifted history
  assign sum       = {1'b0, word, 1'b0} + 18'(newest_word) + 18'(second_word);
  assign avg       = sum[17:2];

  // Phase order X, Y, Z, X
  always_comb begin
    case (phase)
      PH_X:    after = PH_Y;
      PH_Y:    after = PH_Z;
      default: after = PH_X;
    endcase
  end

  // Next state and job for the beat on the input
  always_comb begin
    phase_next       = phase;
    word_count_next  = word_count;
    newest_word_next = newest_word;
    second_word_next = second_word;
    third_word_next  = third_word;
    held_x_next      = held_x;
    held_y_next      = held_y;
    job_valid        = 1'b0;
    job.mode         = JOB_PRESS;
    job.burst_n      = phase_count(PH_X, cfg);
    job.cmd          = phase_cmd(PH_X, cfg);
    job.pos_x        = '0;
    job.pos_y        = '0;

    if (req_type == REQ_PEN) begin
      if (phase == PH_IDLE && pen_down) begin
        job_valid       = accept;
        phase_next      = PH_X;
        word_count_next = '0;
      end
    end else if (phase != PH_IDLE) begin
      third_word_next  = second_word;
      second_word_next = newest_word;
      newest_word_next = word;
      word_count_next  = count_inc;
      if (count_inc >= phase_count(phase, cfg)) begin
        if (phase == PH_X) held_x_next = avg;
        if (phase == PH_Y) held_y_next = avg;
        word_count_next = '0;
        job_valid       = accept;
        if (pen_down) begin
          phase_next  = after;
          job.mode    = JOB_REPORT;
          job.burst_n = phase_count(after, cfg);
          job.cmd     = phase_cmd(after, cfg);
          job.pos_x   = held_x_next;
          job.pos_y   = held_y_next;
        end else begin
          phase_next  = PH_IDLE;
          job.mode    = JOB_RELEASE;
        end
      end
    end
  end

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      word_count  <= '0;
      newest_word <= '0;
      second_word <= '0;
      third_word  <= '0;
      held_x      <= '0;
      held_y      <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      word_count  <= word_count_next;
      newest_word <= newest_word_next;
      second_word <= second_word_next;
      third_word  <= third_word_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
    end
  end

endmodule

[rtl/tss_emitter.sv]
// ----------------------------------------------------------------------------
// tss_emitter
// Job and result regs: a job's results go one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module tss_emitter import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  tss_rsp_if.source   rsp
);

  job_t             job_q;
  logic             busy;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] total_m1;
  logic             adv;
  logic             emit_last;

  kind_t             r_kind;
  logic [CMD_W-1:0]  r_cmd;
  logic              r_touch;
  logic [WORD_W-1:0] r_x, r_y;

  assign total_m1  = (job_q.mode == JOB_RELEASE) ? 5'd1 : job_q.burst_n;
  assign emit_last = (idx == total_m1);
  assign adv       = busy & (~rsp.valid | rsp.ready);
  assign job_ready = ~busy | (adv & emit_last);

  // Result for the current position in the job
  always_comb begin
    r_kind  = KIND_CMD;
    r_cmd   = '0;
    r_touch = 1'b0;
    r_x     = '0;
    r_y     = '0;
    if (idx == '0) begin
      case (job_q.mode)
        JOB_PRESS: begin
          r_kind  = KIND_KEY;
          r_touch = 1'b1;
        end
        JOB_REPORT: begin
          r_kind  = KIND_REPORT;
          r_touch = 1'b1;
          r_x     = job_q.pos_x;
          r_y     = job_q.pos_y;
        end
        default: r_kind = KIND_KEY;
      endcase
    end else if (job_q.mode == JOB_RELEASE) begin
      r_kind = KIND_REPORT;
    end else begin
      r_cmd = job_q.cmd;
      // final command of a burst leaves power-down enable clear
      if (idx == job_q.burst_n) r_cmd[PD_BIT] = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (job_valid) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv & emit_last) begin
        busy <= 1'b0;
      end else if (adv) begin
        idx <= CNT_W'(idx + 5'd1);
      end
      if (adv) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (job_valid) job_q <= job;
    if (adv) begin
      rsp.out_kind     <= r_kind;
      rsp.command_word <= r_cmd;
      rsp.touch        <= r_touch;
      rsp.pos_x        <= r_x;
      rsp.pos_y        <= r_y;
      rsp.last         <= emit_last;
    end
  end

endmodule

[rtl/touch_scan_sequencer.sv]
// ----------------------------------------------------------------------------
// touch_scan_sequencer
// Resistive touch scan sequencer: pen events and converter words in,
// converter commands, key events and position reports out.
// ----------------------------------------------------------------------------
// A beat's job is registered, then its results in the result register.
// Throughput: one input beat a cycle if it causes no result and the emitter
//   is idle; a beat that causes results (up to 17) holds the input until the
//   last is registered, the emitter sending one a cycle unless rsp stalls.
// Reset: synchronous, active high; phase goes idle, history and held
//   coordinates clear, registers return to their default values.
module touch_scan_sequencer import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tss_req_if.sink           req,
  tss_rsp_if.source         rsp
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic accept;

  assign accept = req.valid & req.ready;

  tss_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tss_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .req_type  (req.req_type),
    .pen_down  (req.pen_down),
    .adc_word  (req.adc_word),
    .job_valid (job_valid),
    .job       (job)
  );

  tss_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (req.ready),
    .rsp       (rsp)
  );

endmodule

[rtl/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker import tss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        out_kind,
  input logic [CMD_W-1:0]  command_word,
  input logic              touch,
  input logic [WORD_W-1:0] pos_x,
  input logic [WORD_W-1:0] pos_y,
  input logic              last
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(command_word) && $stable(pos_x)
                                && $stable(out_kind) && $stable(last))
    else $error("result beat changed while stalled");

  // Commands carry no touch or position
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind == KIND_CMD |-> !touch && pos_x == '0 && pos_y == '0)
    else $error("command beat carries position");

  // A release report is zero and ends its group
  a_rel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind == KIND_REPORT && !touch |-> pos_x == '0 && pos_y == '0 && last)
    else $error("release report malformed");

  // Key events and reports carry no command
  a_nocmd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind != KIND_CMD |-> command_word == '0)
    else $error("non-command beat carries a command");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind touch_scan_sequencer tss_checker u_tss_chk (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .out_kind     (rsp.out_kind),
  .command_word (rsp.command_word),
  .touch        (rsp.touch),
  .pos_x        (rsp.pos_x),
  .pos_y        (rsp.pos_y),
  .last         (rsp.last)
);
